[src/sfd_pkg.sv]
package sfd_pkg;

   localparam int POSITION_BITS = 48;

   localparam logic [7:0]  SYNC_FIRST        = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND       = 8'h62;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd8192;
   localparam logic [16:0] FRAME_OVERHEAD    = 17'd8;

   typedef logic [POSITION_BITS-1:0] position_type;

   typedef struct packed {
      logic [47:0] frame_offset;
      logic [7:0]  msg_class;
      logic [7:0]  msg_ident;
      logic [15:0] payload_length;
      logic [16:0] frame_length;
   } result_type;

endpackage

[src/sfd_req_if.sv]
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

[src/sfd_rsp_if.sv]
interface sfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] frame_offset;
   logic [7:0]  msg_class;
   logic [7:0]  msg_ident;
   logic [15:0] payload_length;
   logic [16:0] frame_length;

   modport source (output valid, output frame_offset, output msg_class, output msg_ident,
                   output payload_length, output frame_length, input ready);
   modport sink   (input valid, input frame_offset, input msg_class, input msg_ident,
                   input payload_length, input frame_length, output ready);
endinterface

[src/sfd_csr_if.sv]
interface sfd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[src/sfd_parser.sv]
module sfd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   input  logic [15:0]        len_limit,
   output logic               hit,
   output sfd_pkg::result_type result
);
   import sfd_pkg::*;

   typedef enum logic [3:0] {
      PH_HUNT, PH_SYNC2, PH_CLASS, PH_IDENT, PH_LEN_LO, PH_LEN_HI,
      PH_PAYLOAD, PH_CK_A, PH_CK_B
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [7:0]   sum_a_ff, sum_a_in;
   logic [7:0]   sum_b_ff, sum_b_in;
   logic [7:0]   held_class_ff, held_class_in;
   logic [7:0]   held_ident_ff, held_ident_in;
   logic [15:0]  held_length_ff, held_length_in;
   logic [15:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]   expected_a_ff, expected_a_in;
   position_type byte_position_ff;
   position_type start_position_ff, start_position_in;

   logic [7:0]  acc_a;
   logic [7:0]  acc_b;
   logic [15:0] new_length;

   // Fletcher step; class byte restarts both sums
   always_comb begin
      if (phase_ff == PH_CLASS) begin
         acc_a = data_byte;
         acc_b = data_byte;
      end else begin
         acc_a = sum_a_ff + data_byte;
         acc_b = sum_b_ff + acc_a;
      end
   end

   assign new_length = {data_byte, held_length_ff[7:0]};

   always_comb begin
      phase_in          = phase_ff;
      sum_a_in          = sum_a_ff;
      sum_b_in          = sum_b_ff;
      held_class_in     = held_class_ff;
      held_ident_in     = held_ident_ff;
      held_length_in    = held_length_ff;
      bytes_left_in     = bytes_left_ff;
      expected_a_in     = expected_a_ff;
      start_position_in = start_position_ff;
      hit               = 1'b0;
      case (phase_ff)
         PH_SYNC2: begin
            if (data_byte == SYNC_SECOND) begin
               phase_in = PH_CLASS;
            end else if (data_byte == SYNC_FIRST) begin
               start_position_in = byte_position_ff;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_CLASS: begin
            held_class_in = data_byte;
            sum_a_in      = acc_a;
            sum_b_in      = acc_b;
            phase_in      = PH_IDENT;
         end
         PH_IDENT: begin
            held_ident_in = data_byte;
            sum_a_in      = acc_a;
            sum_b_in      = acc_b;
            phase_in      = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            held_length_in = {8'd0, data_byte};
            sum_a_in       = acc_a;
            sum_b_in       = acc_b;
            phase_in       = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            held_length_in = new_length;
            sum_a_in       = acc_a;
            sum_b_in       = acc_b;
            if (new_length > len_limit) begin
               phase_in = PH_HUNT;
            end else begin
               bytes_left_in = new_length;
               phase_in      = (new_length == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_a_in      = acc_a;
            sum_b_in      = acc_b;
            bytes_left_in = bytes_left_ff - 16'd1;
            if (bytes_left_ff == 16'd1) begin
               phase_in = PH_CK_A;
            end
         end
         PH_CK_A: begin
            expected_a_in = data_byte;
            phase_in      = PH_CK_B;
         end
         PH_CK_B: begin
            hit      = (sum_a_ff == expected_a_ff) && (sum_b_ff == data_byte);
            phase_in = PH_HUNT;
         end
         default: begin
            if (data_byte == SYNC_FIRST) begin
               start_position_in = byte_position_ff;
               phase_in          = PH_SYNC2;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_comb begin
      result.frame_offset   = 48'(start_position_ff);
      result.msg_class      = held_class_ff;
      result.msg_ident      = held_ident_ff;
      result.payload_length = held_length_ff;
      result.frame_length   = {1'b0, held_length_ff} + FRAME_OVERHEAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         sum_a_ff          <= '0;
         sum_b_ff          <= '0;
         held_class_ff     <= '0;
         held_ident_ff     <= '0;
         held_length_ff    <= '0;
         bytes_left_ff     <= '0;
         expected_a_ff     <= '0;
         byte_position_ff  <= '0;
         start_position_ff <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         sum_a_ff          <= sum_a_in;
         sum_b_ff          <= sum_b_in;
         held_class_ff     <= held_class_in;
         held_ident_ff     <= held_ident_in;
         held_length_ff    <= held_length_in;
         bytes_left_ff     <= bytes_left_in;
         expected_a_ff     <= expected_a_in;
         byte_position_ff  <= byte_position_ff + 1'b1;
         start_position_ff <= start_position_in;
      end
   end

endmodule

[src/sync_frame_deframer_fletcher8_top.sv]
// Sync-pair frame deframer with Fletcher-8 check. Takes one stream byte per
// beat, hunts for B5 62, reads class, id and a little-endian length, and emits
// one beat per frame whose check bytes match, carrying the stream offset of
// its first sync byte. Lengths above the csr length limit (reset 8192) drop the
// candidate; hunting restarts on the following byte, with no rescan. Throughput
// is one byte per clock unless the output stalls: the byte lands in an input
// register, the parser state and result update from it, and the result waits
// in an output register, so input stalls only while that register is full and
// held. Result valid is registered as the parser consumes the last check byte.
module sync_frame_deframer_fletcher8_top (
   input logic       clock,
   input logic       reset,
   sfd_req_if.sink   req_bus,
   sfd_rsp_if.source rsp_bus,
   sfd_csr_if.sink   csr_bus
);
   import sfd_pkg::*;

   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        out_vld_ff;
   result_type  out_data_ff;
   logic [15:0] max_len_ff;

   logic        advance;
   logic        hit;
   result_type  result;

   assign advance       = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !in_vld_ff || advance;
   assign csr_bus.ready = 1'b1;

   sfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .len_limit (max_len_ff),
      .hit       (hit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         max_len_ff <= MAX_PAYLOAD_RESET;
      end else begin
         if (req_bus.ready) begin
            in_vld_ff <= req_bus.valid;
         end
         if (advance) begin
            out_vld_ff <= hit;
         end else if (rsp_bus.ready) begin
            out_vld_ff <= 1'b0;
         end
         if (csr_bus.valid) begin
            max_len_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
      end
      if (advance && hit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_bus.valid          = out_vld_ff;
   assign rsp_bus.frame_offset   = out_data_ff.frame_offset;
   assign rsp_bus.msg_class      = out_data_ff.msg_class;
   assign rsp_bus.msg_ident      = out_data_ff.msg_ident;
   assign rsp_bus.payload_length = out_data_ff.payload_length;
   assign rsp_bus.frame_length   = out_data_ff.frame_length;

endmodule
